### rtl/core/lzw_variable_width_encoder_macros.svh
// Assertion macros for the LZW encoder checker.
// Both expect clk and rst_n in the scope where they are used.
`ifndef LZW_VARIABLE_WIDTH_ENCODER_MACROS_SVH
`define LZW_VARIABLE_WIDTH_ENCODER_MACROS_SVH

// Consequent checked in the same cycle.
`define LVWE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lvwe assertion failed");

// Consequent checked in the cycle after the antecedent.
`define LVWE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lvwe assertion failed");

`endif

### rtl/core/lvwe_pkg.sv
`timescale 1ns / 1ps
package lvwe_pkg;
    localparam int unsigned CODE_CLEAR      = 256;
    localparam int unsigned CODE_EOD        = 257;
    localparam int unsigned CODE_FIRST      = 258;
    localparam int unsigned WIDTH_START     = 9;
    localparam int unsigned WIDTH_CFG_RESET = 12;
    localparam int unsigned CFG_W           = 4;
    // dictionary entries carry a generation tag; a full wipe runs on tag wrap
    localparam int unsigned EPOCH_W         = 4;
endpackage

### rtl/core/lzw_variable_width_encoder.sv
// Flow: a request that extends a match goes through a dictionary read, then a check; the
// first request of a stream needs no read. Each code packed, the final padding and each
// packed byte is a step of its own, a stalled packed byte holds the block, and new bytes
// are stalled until the block is idle again.
// Reset: control state clears asynchronously, then a clearing pass sweeps every one of the
// 2^(MAX_CODE_BITS+8) dictionary entries; the same pass follows every 16th clear or stream end.
`timescale 1ns / 1ps
module lzw_variable_width_encoder #(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_valid,
    output logic                         byte_stall,
    input  logic [7:0]                   data_byte,
    input  logic                         stream_last,
    output logic                         pack_valid,
    input  logic                         pack_stall,
    output logic [7:0]                   packed_byte,
    output logic                         run_last,
    output logic                         stream_end,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lvwe_pkg::CFG_W-1:0]   cfg_data
);

    localparam int CW     = MAX_CODE_BITS;
    localparam int AW     = CW + 8;
    localparam int DEPTH  = 1 << AW;
    localparam int EW     = lvwe_pkg::EPOCH_W;
    localparam int MW     = EW + CW;
    localparam int NW     = CW + 1;
    localparam int WW     = $clog2(CW + 2);
    localparam int EMIT_W = CW + 1;
    localparam int ACC_W  = CW + 8;
    localparam int KW     = $clog2(ACC_W + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    localparam logic [WW-1:0]     W_START   = WW'(lvwe_pkg::WIDTH_START);
    localparam logic [NW-1:0]     NFC_FIRST = NW'(lvwe_pkg::CODE_FIRST);
    localparam logic [EMIT_W-1:0] C_CLEAR   = EMIT_W'(lvwe_pkg::CODE_CLEAR);
    localparam logic [EMIT_W-1:0] C_EOD     = EMIT_W'(lvwe_pkg::CODE_EOD);

    logic [MW-1:0] dict_mem [DEPTH];
    logic [MW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic [2:0]                 state_reg, state_next;
    logic [AW-1:0]              clr_addr_reg, clr_addr_next;
    logic [EW-1:0]              epoch_reg, epoch_next;
    logic                       wipe_reg, wipe_next;
    logic [CW-1:0]              prefix_reg, prefix_next;
    logic                       have_prefix_reg, have_prefix_next;
    logic [NW-1:0]              nfc_reg, nfc_next;
    logic [WW-1:0]              width_reg, width_next;
    logic [lvwe_pkg::CFG_W-1:0] max_width_reg, max_width_next;
    logic                       fin_reg, fin_next;
    logic                       em_pfx_reg, em_pfx_next;
    logic                       em_clr_reg, em_clr_next;
    logic                       em_fin_reg, em_fin_next;
    logic                       em_eod_reg, em_eod_next;
    logic [KW-1:0]              cnt_reg, cnt_next;
    logic                       pack_valid_reg, pack_valid_next;

    logic [7:0]                 byte_reg, byte_next;
    logic [CW-1:0]              pfx_code_reg, pfx_code_next;
    logic [WW-1:0]              pfx_w_reg, pfx_w_next;
    logic [WW-1:0]              clr_w_reg, clr_w_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [7:0]                 packed_byte_reg, packed_byte_next;
    logic                       run_last_reg, run_last_next;
    logic                       stream_end_reg, stream_end_next;

    logic [4:0]        cfg_ext;
    logic [WW-1:0]     eff_max;
    logic [EW-1:0]     rd_tag;
    logic [CW-1:0]     rd_child;
    logic              hit;
    logic [NW-1:0]     nfc_inc;
    logic [NW-1:0]     nfc_pow;
    logic [WW-1:0]     w_inc;
    logic [EMIT_W-1:0] code_sel;
    logic [WW-1:0]     w_sel;
    logic [EMIT_W-1:0] code_mask;
    logic [KW-1:0]     cnt_after;
    logic              em_any;
    logic              more;
    logic              is_last;
    logic              out_free;

    assign byte_stall  = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign pack_valid  = pack_valid_reg;
    assign packed_byte = packed_byte_reg;
    assign run_last    = run_last_reg;
    assign stream_end  = stream_end_reg;

    assign cfg_ext = {1'b0, max_width_reg};
    always_comb
    begin
        if (cfg_ext < 5'(lvwe_pkg::WIDTH_START))
        begin
            eff_max = W_START;
        end
        else if (cfg_ext > 5'(CW))
        begin
            eff_max = WW'(CW);
        end
        else
        begin
            eff_max = WW'(cfg_ext);
        end
    end

    assign rd_tag   = rd_data_reg[MW-1:CW];
    assign rd_child = rd_data_reg[CW-1:0];
    assign hit      = (rd_tag == epoch_reg) && (rd_child != '0);
    assign nfc_inc  = nfc_reg + NW'(1);
    assign nfc_pow  = NW'(1) << width_reg;
    assign w_inc    = width_reg + WW'(1);

    // code picked for the packer, in stream order
    always_comb
    begin
        if (em_pfx_reg)
        begin
            code_sel = {1'b0, pfx_code_reg};
            w_sel    = pfx_w_reg;
        end
        else if (em_clr_reg)
        begin
            code_sel = C_CLEAR;
            w_sel    = clr_w_reg;
        end
        else if (em_fin_reg)
        begin
            code_sel = {1'b0, prefix_reg};
            w_sel    = width_reg;
        end
        else if (em_eod_reg)
        begin
            code_sel = C_EOD;
            w_sel    = width_reg;
        end
        else
        begin
            code_sel = '0;
            w_sel    = WW'(KW'(8) - cnt_reg);
        end
    end

    assign code_mask = ~({EMIT_W{1'b1}} << w_sel);
    assign cnt_after = cnt_reg - KW'(8);
    assign em_any    = em_pfx_reg | em_clr_reg | em_fin_reg | em_eod_reg;
    assign more      = em_any || (fin_reg && (cnt_after != '0));
    assign is_last   = (cnt_after < KW'(8)) && !more;
    assign out_free  = !pack_valid_reg || !pack_stall;

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        epoch_next       = epoch_reg;
        wipe_next        = wipe_reg;
        prefix_next      = prefix_reg;
        have_prefix_next = have_prefix_reg;
        nfc_next         = nfc_reg;
        width_next       = width_reg;
        max_width_next   = max_width_reg;
        fin_next         = fin_reg;
        em_pfx_next      = em_pfx_reg;
        em_clr_next      = em_clr_reg;
        em_fin_next      = em_fin_reg;
        em_eod_next      = em_eod_reg;
        cnt_next         = cnt_reg;
        pack_valid_next  = pack_valid_reg && pack_stall;
        byte_next        = byte_reg;
        pfx_code_next    = pfx_code_reg;
        pfx_w_next       = pfx_w_reg;
        clr_w_next       = clr_w_reg;
        acc_next         = acc_reg;
        packed_byte_next = packed_byte_reg;
        run_last_next    = run_last_reg;
        stream_end_next  = stream_end_reg;
        mem_we           = 1'b0;
        mem_waddr        = clr_addr_reg;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = {prefix_reg, data_byte};

        if (cfg_valid)
        begin
            max_width_next = cfg_data;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1)
                begin
                    wipe_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (byte_valid)
                begin
                    fin_next  = stream_last;
                    byte_next = data_byte;
                    if (!have_prefix_reg)
                    begin
                        prefix_next      = {{(CW-8){1'b0}}, data_byte};
                        have_prefix_next = 1'b1;
                        if (stream_last)
                        begin
                            em_fin_next = 1'b1;
                            em_eod_next = 1'b1;
                            state_next  = S_EMIT;
                        end
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                if (hit)
                begin
                    prefix_next = rd_child;
                end
                else
                begin
                    em_pfx_next   = 1'b1;
                    pfx_code_next = prefix_reg;
                    pfx_w_next    = width_reg;
                    mem_we        = 1'b1;
                    mem_waddr     = {prefix_reg, byte_reg};
                    mem_wdata     = {epoch_reg, nfc_reg[CW-1:0]};
                    prefix_next   = {{(CW-8){1'b0}}, byte_reg};
                    nfc_next      = nfc_inc;
                    if (nfc_inc == nfc_pow)
                    begin
                        if (w_inc > eff_max)
                        begin
                            em_clr_next = 1'b1;
                            clr_w_next  = w_inc;
                            width_next  = W_START;
                            nfc_next    = NFC_FIRST;
                            epoch_next  = epoch_reg + EW'(1);
                            if (epoch_reg == '1)
                            begin
                                wipe_next = 1'b1;
                            end
                        end
                        else
                        begin
                            width_next = w_inc;
                        end
                    end
                end
                if (fin_reg)
                begin
                    em_fin_next = 1'b1;
                    em_eod_next = 1'b1;
                end
                if (!hit || fin_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                acc_next = (acc_reg << w_sel) | ACC_W'(code_sel & code_mask);
                cnt_next = cnt_reg + KW'(w_sel);
                if (em_pfx_reg)
                begin
                    em_pfx_next = 1'b0;
                end
                else if (em_clr_reg)
                begin
                    em_clr_next = 1'b0;
                end
                else if (em_fin_reg)
                begin
                    em_fin_next = 1'b0;
                end
                else if (em_eod_reg)
                begin
                    em_eod_next = 1'b0;
                end
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    pack_valid_next  = 1'b1;
                    packed_byte_next = 8'(acc_reg >> cnt_after);
                    run_last_next    = is_last;
                    stream_end_next  = is_last && fin_reg;
                    cnt_next         = cnt_after;
                    if (is_last)
                    begin
                        state_next = wipe_reg ? S_CLEAR : S_IDLE;
                        if (fin_reg)
                        begin
                            prefix_next      = '0;
                            have_prefix_next = 1'b0;
                            nfc_next         = NFC_FIRST;
                            width_next       = W_START;
                            epoch_next       = epoch_reg + EW'(1);
                            if (epoch_reg == '1)
                            begin
                                state_next = S_CLEAR;
                            end
                        end
                    end
                    else if (cnt_after < KW'(8))
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dict_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= dict_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            epoch_reg       <= '0;
            wipe_reg        <= 1'b0;
            prefix_reg      <= '0;
            have_prefix_reg <= 1'b0;
            nfc_reg         <= NFC_FIRST;
            width_reg       <= W_START;
            max_width_reg   <= lvwe_pkg::CFG_W'(lvwe_pkg::WIDTH_CFG_RESET);
            fin_reg         <= 1'b0;
            em_pfx_reg      <= 1'b0;
            em_clr_reg      <= 1'b0;
            em_fin_reg      <= 1'b0;
            em_eod_reg      <= 1'b0;
            cnt_reg         <= '0;
            pack_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            epoch_reg       <= epoch_next;
            wipe_reg        <= wipe_next;
            prefix_reg      <= prefix_next;
            have_prefix_reg <= have_prefix_next;
            nfc_reg         <= nfc_next;
            width_reg       <= width_next;
            max_width_reg   <= max_width_next;
            fin_reg         <= fin_next;
            em_pfx_reg      <= em_pfx_next;
            em_clr_reg      <= em_clr_next;
            em_fin_reg      <= em_fin_next;
            em_eod_reg      <= em_eod_next;
            cnt_reg         <= cnt_next;
            pack_valid_reg  <= pack_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg        <= byte_next;
        pfx_code_reg    <= pfx_code_next;
        pfx_w_reg       <= pfx_w_next;
        clr_w_reg       <= clr_w_next;
        acc_reg         <= acc_next;
        packed_byte_reg <= packed_byte_next;
        run_last_reg    <= run_last_next;
        stream_end_reg  <= stream_end_next;
    end

endmodule

### rtl/core/lvwe_checker.sv
`timescale 1ns / 1ps
`include "lzw_variable_width_encoder_macros.svh"
module lvwe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       byte_valid,
    input logic       byte_stall,
    input logic       stream_last,
    input logic       pack_valid,
    input logic       pack_stall,
    input logic [7:0] packed_byte,
    input logic       run_last,
    input logic       stream_end
);

    `LVWE_ASSERT_NEXT(a_out_hold, pack_valid && pack_stall, pack_valid && $stable(packed_byte) && $stable(run_last) && $stable(stream_end))

    `LVWE_ASSERT_NOW(a_end_is_last, pack_valid && stream_end, run_last)

    `LVWE_ASSERT_NEXT(a_last_busy, byte_valid && !byte_stall && stream_last, byte_stall)

    `LVWE_ASSERT_NOW(a_busy_mid_run, pack_valid && !pack_stall && !run_last, byte_stall)

endmodule

bind lzw_variable_width_encoder lvwe_checker u_lvwe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .stream_last (stream_last),
    .pack_valid  (pack_valid),
    .pack_stall  (pack_stall),
    .packed_byte (packed_byte),
    .run_last    (run_last),
    .stream_end  (stream_end)
);
